### hdl/pstdoa_pkg.sv
// pstdoa_pkg: shared types and constants of the point-source TDoA cost/gradient block.
// Sequencer state and operation codes, register indexes, field widths.
// No dependencies.
package pstdoa_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_X     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_Y     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_Z     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_TIME  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WAVE_SPEED   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_FREE   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_RESULT_SHIFT = 3'd6;

    // speed is unsigned Q1.15
    localparam int SPEED_W    = 16;
    localparam int SPEED_FRAC = 15;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd32768;

    // result shift, plus the extra scaling of the time and speed terms
    localparam int SHIFT_W = 6;
    localparam int SHAMT_W = 7;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd32;
    localparam logic [SHAMT_W-1:0] TIME_EXTRA  = 7'd30;
    localparam logic [SHAMT_W-1:0] SPEED_EXTRA = 7'd15;

    // accumulators
    localparam int ACC_W   = 64;
    localparam int NUM_ACC = 6;
    localparam int ACC_IDX_W = 3;
    localparam logic [ACC_IDX_W-1:0] ACC_COST  = 3'd0;
    localparam logic [ACC_IDX_W-1:0] ACC_GX    = 3'd1;
    localparam logic [ACC_IDX_W-1:0] ACC_GY    = 3'd2;
    localparam logic [ACC_IDX_W-1:0] ACC_GZ    = 3'd3;
    localparam logic [ACC_IDX_W-1:0] ACC_TIME  = 3'd4;
    localparam logic [ACC_IDX_W-1:0] ACC_SPEED = 3'd5;
    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // result item layout
    localparam int COST_W     = 63;
    localparam int OUT_DATA_W = ((COST_W + 5*ACC_W + 7) / 8) * 8;

    // multiplier digit
    localparam int DIGIT_W = 8;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LOAD = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_POST = 6'b001000,
        ST_ACC  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    // one product per operation, in sequence order
    typedef enum logic [3:0] {
        OP_SDT  = 4'd0,   // s*dt
        OP_DX2  = 4'd1,   // dx^2
        OP_DY2  = 4'd2,
        OP_DZ2  = 4'd3,
        OP_SD2  = 4'd4,   // sd^2
        OP_COST = 4'd5,   // fi^2
        OP_GX   = 4'd6,   // fi*dx
        OP_GY   = 4'd7,
        OP_GZ   = 4'd8,
        OP_SS   = 4'd9,   // s^2
        OP_T1   = 4'd10,  // s^2*dt
        OP_GT   = 4'd11,  // s^2*dt*fi
        OP_U    = 4'd12,  // s*dt*dt
        OP_GS   = 4'd13   // s*dt^2*fi
    } op_t;

endpackage

### hdl/point_source_tdoa_cost_gradient.sv
// point_source_tdoa_cost_gradient: top level, TDoA residual cost and gradient accumulator.
// Depends on pstdoa_pkg.
//
// Antennas stream in one item at a time (x, y, z and arrival time, signed 1/8 m units;
// s_tlast marks the last antenna). For the candidate source held in the configuration
// registers each antenna gives fi = |source - antenna|^2 - (speed*dt)^2, and the block
// adds fi^2, 4*d*fi (x, y, z), -4*s^2*dt*fi and, when the speed is free, -4*s*dt^2*fi
// into six 64-bit saturating accumulators, each term floored by 2^result_shift first
// (by 2^30 more for the time term and 2^15 more for the speed term). After the last
// antenna one result item carries the sums and the sums are cleared. All products go
// through one shared multiplier that takes 8 bits of one operand per cycle
// (digit-serial, MSB first), under a small sequencer; an item runs 14 products (12
// with the speed fixed) through load, multiply and post steps, each accumulated term
// also taking an accumulate step; s_tready is low meanwhile. A finished result waits
// in its own output register, so the next antenna is accepted before the result is
// taken. Configuration registers may be written only while no item is in flight.
module point_source_tdoa_cost_gradient #(
    parameter int COORD_WIDTH = 20
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    // configuration write port
    input  logic                                       cfg_wr_en,
    input  logic [pstdoa_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [((COORD_WIDTH > 16) ? COORD_WIDTH : 16)-1:0] cfg_wdata,
    // antenna items
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // antenna_x, antenna_y, antenna_z, antenna_time (low to high), zero padded
    input  logic [((4*COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    input  logic                                       s_tlast,   // last_antenna
    // result items
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // cost, grad_x, grad_y, grad_z, grad_time, grad_speed (low to high), zero padded
    output logic [pstdoa_pkg::OUT_DATA_W-1:0]          m_tdata
);
    import pstdoa_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;            // source - antenna
    localparam int SPW  = W + SPEED_W + 1;  // s*dt
    localparam int SDW  = W + 2;            // floor(s*dt / 2^15)
    localparam int FW   = 2*W + 4;          // residual fi
    localparam int AW   = (2*W + 17 > W + 33) ? 2*W + 17 : W + 33;  // wide operand
    localparam int NB   = (FW + DIGIT_W - 1) / DIGIT_W;  // digits of the widest narrow operand
    localparam int BWP  = NB * DIGIT_W;
    localparam int PW   = AW + BWP;         // product
    localparam int TW   = PW + 3;           // scaled and negated term
    localparam int SUMW = ((TW > ACC_W) ? TW : ACC_W) + 1;
    localparam int CNT_W = $clog2(NB + 1);

    // digits per operand class; the narrow operand is left aligned in b_reg
    localparam int ND_S  = (SPEED_W + 1 + DIGIT_W - 1) / DIGIT_W;
    localparam int ND_D  = (DW + DIGIT_W - 1) / DIGIT_W;
    localparam int ND_SD = (SDW + DIGIT_W - 1) / DIGIT_W;
    localparam int ND_F  = NB;
    localparam int SHB_S  = DIGIT_W * (NB - ND_S);
    localparam int SHB_D  = DIGIT_W * (NB - ND_D);
    localparam int SHB_SD = DIGIT_W * (NB - ND_SD);

    // ---------------- configuration registers ----------------
    logic signed [W-1:0]     src_x_reg, src_y_reg, src_z_reg, src_t_reg;
    logic [SPEED_W-1:0]      speed_reg;
    logic                    free_reg;
    logic [SHIFT_W-1:0]      shift_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_x_reg <= '0;
            src_y_reg <= '0;
            src_z_reg <= '0;
            src_t_reg <= '0;
            speed_reg <= SPEED_RESET;
            free_reg  <= 1'b0;
            shift_reg <= SHIFT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SOURCE_X:     src_x_reg <= cfg_wdata[W-1:0];
                REG_SOURCE_Y:     src_y_reg <= cfg_wdata[W-1:0];
                REG_SOURCE_Z:     src_z_reg <= cfg_wdata[W-1:0];
                REG_SOURCE_TIME:  src_t_reg <= cfg_wdata[W-1:0];
                REG_WAVE_SPEED:   speed_reg <= cfg_wdata[SPEED_W-1:0];
                REG_SPEED_FREE:   free_reg  <= cfg_wdata[0];
                REG_RESULT_SHIFT: shift_reg <= cfg_wdata[SHIFT_W-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // ---------------- input unpack ----------------
    logic signed [W-1:0] ant_x, ant_y, ant_z, ant_t;
    assign ant_x = s_tdata[W-1:0];
    assign ant_y = s_tdata[2*W-1:W];
    assign ant_z = s_tdata[3*W-1:2*W];
    assign ant_t = s_tdata[4*W-1:3*W];

    // ---------------- sequencer state ----------------
    state_t             state_reg;
    op_t                op_reg, op_next;
    logic               last_reg;
    logic               op_last, is_term;
    logic [CNT_W-1:0]   cnt_reg;
    logic               first_reg;
    logic               m_tvalid_reg;
    logic               out_free;
    logic               in_accept;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // ---------------- per-item operands ----------------
    logic signed [DW-1:0]  dx_reg, dy_reg, dz_reg, dt_reg;
    logic signed [SPW-1:0] sdp_reg;
    logic signed [SDW-1:0] sd_reg;
    logic signed [FW-1:0]  fi_reg;
    logic signed [AW-1:0]  tmp_reg;   // s^2, then s^2*dt, or s*dt^2

    // ---------------- shared multiplier ----------------
    logic signed [AW-1:0]        a_reg, a_sel;
    logic [BWP-1:0]              b_reg, b_sel;
    logic [CNT_W-1:0]            nd_sel;
    logic signed [PW-1:0]        p_reg, p_next;
    logic signed [DIGIT_W:0]     digit;
    logic signed [AW+DIGIT_W:0]  part;

    // top digit of the narrow operand carries its sign, the rest are unsigned
    assign digit  = first_reg ? {b_reg[BWP-1], b_reg[BWP-1 -: DIGIT_W]}
                              : {1'b0, b_reg[BWP-1 -: DIGIT_W]};
    assign part   = a_reg * digit;
    assign p_next = (p_reg <<< DIGIT_W) + PW'(part);

    // operand routing for each product
    always_comb begin
        a_sel  = '0;
        b_sel  = '0;
        nd_sel = CNT_W'(1);
        case (op_reg)
            OP_SDT: begin
                a_sel  = AW'(dt_reg);
                b_sel  = BWP'({1'b0, speed_reg}) << SHB_S;
                nd_sel = CNT_W'(ND_S);
            end
            OP_DX2: begin
                a_sel  = AW'(dx_reg);
                b_sel  = BWP'(dx_reg) << SHB_D;
                nd_sel = CNT_W'(ND_D);
            end
            OP_DY2: begin
                a_sel  = AW'(dy_reg);
                b_sel  = BWP'(dy_reg) << SHB_D;
                nd_sel = CNT_W'(ND_D);
            end
            OP_DZ2: begin
                a_sel  = AW'(dz_reg);
                b_sel  = BWP'(dz_reg) << SHB_D;
                nd_sel = CNT_W'(ND_D);
            end
            OP_SD2: begin
                a_sel  = AW'(sd_reg);
                b_sel  = BWP'(sd_reg) << SHB_SD;
                nd_sel = CNT_W'(ND_SD);
            end
            OP_COST: begin
                a_sel  = AW'(fi_reg);
                b_sel  = BWP'(fi_reg);
                nd_sel = CNT_W'(ND_F);
            end
            OP_GX: begin
                a_sel  = AW'(fi_reg);
                b_sel  = BWP'(dx_reg) << SHB_D;
                nd_sel = CNT_W'(ND_D);
            end
            OP_GY: begin
                a_sel  = AW'(fi_reg);
                b_sel  = BWP'(dy_reg) << SHB_D;
                nd_sel = CNT_W'(ND_D);
            end
            OP_GZ: begin
                a_sel  = AW'(fi_reg);
                b_sel  = BWP'(dz_reg) << SHB_D;
                nd_sel = CNT_W'(ND_D);
            end
            OP_SS: begin
                a_sel  = AW'({1'b0, speed_reg});
                b_sel  = BWP'({1'b0, speed_reg}) << SHB_S;
                nd_sel = CNT_W'(ND_S);
            end
            OP_T1: begin
                a_sel  = tmp_reg;
                b_sel  = BWP'(dt_reg) << SHB_D;
                nd_sel = CNT_W'(ND_D);
            end
            OP_GT: begin
                a_sel  = tmp_reg;
                b_sel  = BWP'(fi_reg);
                nd_sel = CNT_W'(ND_F);
            end
            OP_U: begin
                a_sel  = AW'(sdp_reg);
                b_sel  = BWP'(dt_reg) << SHB_D;
                nd_sel = CNT_W'(ND_D);
            end
            OP_GS: begin
                a_sel  = tmp_reg;
                b_sel  = BWP'(fi_reg);
                nd_sel = CNT_W'(ND_F);
            end
            default: ;
        endcase
    end

    // next product, and whether this one feeds an accumulator
    always_comb begin
        op_next = OP_SDT;
        op_last = 1'b0;
        is_term = 1'b0;
        case (op_reg)
            OP_SDT:  op_next = OP_DX2;
            OP_DX2:  op_next = OP_DY2;
            OP_DY2:  op_next = OP_DZ2;
            OP_DZ2:  op_next = OP_SD2;
            OP_SD2:  op_next = OP_COST;
            OP_COST: begin
                op_next = OP_GX;
                is_term = 1'b1;
            end
            OP_GX: begin
                op_next = OP_GY;
                is_term = 1'b1;
            end
            OP_GY: begin
                op_next = OP_GZ;
                is_term = 1'b1;
            end
            OP_GZ: begin
                op_next = OP_SS;
                is_term = 1'b1;
            end
            OP_SS:   op_next = OP_T1;
            OP_T1:   op_next = OP_GT;
            OP_GT: begin
                op_next = OP_U;
                op_last = !free_reg;   // speed term skipped when the speed is fixed
                is_term = 1'b1;
            end
            OP_U:    op_next = OP_GS;
            OP_GS: begin
                op_last = 1'b1;
                is_term = 1'b1;
            end
            default: op_last = 1'b1;
        endcase
    end

    // ---------------- term scaling ----------------
    logic signed [TW-1:0]  p_ext, scaled, signed_term, term_next, term_reg;
    logic [SHAMT_W-1:0]    shamt;
    logic [ACC_IDX_W-1:0]  acc_idx;

    always_comb begin
        p_ext       = TW'(p_reg);
        scaled      = p_ext <<< 2;      // factor 4 of the gradients
        signed_term = scaled;
        shamt       = {1'b0, shift_reg};
        acc_idx     = ACC_COST;
        case (op_reg)
            OP_COST: scaled = p_ext;
            OP_GX:   acc_idx = ACC_GX;
            OP_GY:   acc_idx = ACC_GY;
            OP_GZ:   acc_idx = ACC_GZ;
            OP_GT: begin
                signed_term = -scaled;
                shamt       = {1'b0, shift_reg} + TIME_EXTRA;
                acc_idx     = ACC_TIME;
            end
            OP_GS: begin
                signed_term = -scaled;
                shamt       = {1'b0, shift_reg} + SPEED_EXTRA;
                acc_idx     = ACC_SPEED;
            end
            default: ;
        endcase
        if (op_reg == OP_COST) begin
            signed_term = scaled;
        end
        term_next = signed_term >>> shamt;   // floor toward minus infinity
    end

    // ---------------- saturating accumulate ----------------
    logic signed [ACC_W-1:0]   acc_reg [NUM_ACC];
    logic signed [SUMW-1:0]    sum;
    logic [SUMW-ACC_W:0]       sum_top;
    logic [ACC_W-1:0]          acc_next;

    always_comb begin
        sum     = SUMW'(acc_reg[acc_idx]) + SUMW'(term_reg);
        sum_top = sum[SUMW-1:ACC_W-1];
        if ((&sum_top) || !(|sum_top)) begin
            acc_next = sum[ACC_W-1:0];
        end else if (sum[SUMW-1]) begin
            acc_next = ACC_MIN;
        end else begin
            acc_next = ACC_MAX;
        end
    end

    // ---------------- control ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_SDT;
            cnt_reg   <= '0;
            first_reg <= 1'b0;
            last_reg  <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        last_reg  <= s_tlast;
                        op_reg    <= OP_SDT;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    cnt_reg   <= nd_sel;
                    first_reg <= 1'b1;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    first_reg <= 1'b0;
                    cnt_reg   <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1)) begin
                        state_reg <= ST_POST;
                    end
                end
                ST_POST: begin
                    if (is_term) begin
                        state_reg <= ST_ACC;
                    end else begin
                        op_reg    <= op_next;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_ACC: begin
                    if (op_last) begin
                        state_reg <= ST_DONE;
                    end else begin
                        op_reg    <= op_next;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_DONE: begin
                    // a result waits here only while the output register is still full
                    if (!last_reg || out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            dx_reg <= DW'(src_x_reg) - DW'(ant_x);
            dy_reg <= DW'(src_y_reg) - DW'(ant_y);
            dz_reg <= DW'(src_z_reg) - DW'(ant_z);
            dt_reg <= DW'(src_t_reg) - DW'(ant_t);
        end
        if (state_reg == ST_LOAD) begin
            a_reg <= a_sel;
            b_reg <= b_sel;
            p_reg <= '0;
        end
        if (state_reg == ST_MUL) begin
            p_reg <= p_next;
            b_reg <= b_reg << DIGIT_W;
        end
        if (state_reg == ST_POST) begin
            term_reg <= term_next;
            case (op_reg)
                OP_SDT: begin
                    sdp_reg <= SPW'(p_reg);
                    sd_reg  <= SDW'(p_reg >>> SPEED_FRAC);
                end
                OP_DX2:  fi_reg  <= FW'(p_reg);
                OP_DY2:  fi_reg  <= fi_reg + FW'(p_reg);
                OP_DZ2:  fi_reg  <= fi_reg + FW'(p_reg);
                OP_SD2:  fi_reg  <= fi_reg - FW'(p_reg);
                OP_SS:   tmp_reg <= AW'(p_reg);
                OP_T1:   tmp_reg <= AW'(p_reg);
                OP_U:    tmp_reg <= AW'(p_reg);
                default: ;
            endcase
        end
    end

    // accumulators: reset to zero, cleared when their result is handed over
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_ACC; i++) begin
                acc_reg[i] <= '0;
            end
        end else if (state_reg == ST_ACC) begin
            acc_reg[acc_idx] <= acc_next;
        end else if (state_reg == ST_DONE && last_reg && out_free) begin
            for (int i = 0; i < NUM_ACC; i++) begin
                acc_reg[i] <= '0;
            end
        end
    end

    // ---------------- result register ----------------
    logic [OUT_DATA_W-1:0] out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && last_reg && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && last_reg && out_free) begin
            // cost sum never goes negative, its sign bit is dropped
            out_reg <= OUT_DATA_W'({acc_reg[ACC_SPEED], acc_reg[ACC_TIME], acc_reg[ACC_GZ],
                                    acc_reg[ACC_GY], acc_reg[ACC_GX],
                                    acc_reg[ACC_COST][COST_W-1:0]});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

endmodule

### hdl/pstdoa_checker.sv
// pstdoa_checker: port-level assertions for point_source_tdoa_cost_gradient, with its bind.
// Depends on pstdoa_pkg and the top level's ports.
module pstdoa_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [pstdoa_pkg::OUT_DATA_W-1:0] m_tdata
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // an accepted antenna keeps the block busy for the following cycles
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted item");

    // a new result only appears out of a finished item
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result raised while the block was idle");

    // reset empties the output register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind point_source_tdoa_cost_gradient pstdoa_checker u_pstdoa_checker (.*);
